// ===== sv/mbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared constants, register and mode codes, control types and helper
// functions for the multi-mode byte cipher.
// ----------------------------------------------------------------------------
package mbc_pkg;

  // Key storage and position sizing.
  localparam int unsigned KEY_MAX_BYTES = 16;
  localparam int unsigned KEY_WORD_W    = 64;
  localparam int unsigned KLEN_W        = 5;
  localparam int unsigned POS_W         = 4;
  localparam int unsigned CFG_IDX_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH    = 3'd4;

  // Cipher mode codes.
  localparam logic [2:0] MODE_XOR       = 3'd0;
  localparam logic [2:0] MODE_CAESAR    = 3'd1;
  localparam logic [2:0] MODE_VIGENERE  = 3'd2;
  localparam logic [2:0] MODE_XORSHIFT  = 3'd3;
  localparam logic [2:0] MODE_ROTATE    = 3'd4;

  // Hash constants for the keystream seed.
  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [31:0] SEED_ALT   = 32'd2463534242;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;         // latch the byte and start the key walk
    logic step;         // fold one key byte into sum and hash
    logic seal;         // finish the walk, fix a zero seed
    logic xform;        // transform a byte into the output register
    logic use_held;     // transform the latched byte instead of the input
  } mbc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;    // every valid key byte has been folded in
    logic out_busy;     // output register full and not drained this cycle
  } mbc_stat_t;

  // Key length clamped to the key storage.
  function automatic logic [KLEN_W-1:0] eff_len(input logic [KLEN_W-1:0] len);
    if (len > KLEN_W'(KEY_MAX_BYTES)) begin
      return KLEN_W'(KEY_MAX_BYTES);
    end
    return len;
  endfunction

  // Pick one key byte from the two key words.
  function automatic logic [7:0] key_byte(input logic [KEY_WORD_W-1:0] lo,
                                          input logic [KEY_WORD_W-1:0] hi,
                                          input logic [POS_W-1:0] idx);
    logic [KEY_WORD_W-1:0] w;
    w = idx[3] ? hi : lo;
    return w[{idx[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] s);
    logic [15:0] t;
    t = {v, v} << s;
    return t[15:8];
  endfunction

  function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] s);
    logic [15:0] t;
    t = {v, v} >> s;
    return t[7:0];
  endfunction

endpackage : mbc_pkg
`default_nettype wire

// ===== sv/mbc_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_in_if
// Input channel of the byte cipher: one data byte and a message start flag
// per beat.
// ----------------------------------------------------------------------------
interface mbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_start;

  modport source (output valid, output data_byte, output message_start, input ready);
  modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface : mbc_in_if
`default_nettype wire

// ===== sv/mbc_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_out_if
// Output channel of the byte cipher: one transformed byte per beat.
// ----------------------------------------------------------------------------
interface mbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface : mbc_out_if
`default_nettype wire

// ===== sv/multi_mode_byte_cipher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_mode_byte_cipher
// Byte stream cipher with xor, caesar, vigenere, xorshift keystream and
// rotate-xor modes, keyed from up to sixteen configured key bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Configure mode, direction, key length and the two key words through the
//   write port (cfg_we, cfg_index, cfg_data) while no byte is in flight.
//   Bytes enter on in_ch with a message_start flag and leave on out_ch, one
//   result beat per input beat, in order.
// Flow and throughput:
//   A byte without message_start is transformed in the cycle it is taken and
//   shows on out_ch the next cycle; one byte per cycle is sustained while
//   out_ch.ready stays high. A byte with message_start first runs the key walk,
//   one key byte per cycle through a single 32x32 multiplier for the hash,
//   over the key length (capped at sixteen), before its result is registered.
// Reset (rst, synchronous): clears configuration, key position, sum and
//   keystream; no result is pending afterwards.
// Stall: the output register holds its beat while out_ch.ready is low; a new
//   input beat is taken in the cycle that beat drains, never while it is stuck.
// ----------------------------------------------------------------------------
module multi_mode_byte_cipher (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [mbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mbc_pkg::KEY_WORD_W-1:0] cfg_data,
  mbc_in_if.sink                              in_ch,
  mbc_out_if.source                           out_ch
);
  import mbc_pkg::*;

  mbc_cmd_t  cmd;
  mbc_stat_t stat;

  mbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_start (in_ch.message_start),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mbc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (in_ch.data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte)
  );

endmodule : multi_mode_byte_cipher
`default_nettype wire

// ===== sv/mbc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_ctrl
// Controller of the byte cipher. Accepts input beats, runs the key walk on a
// message start and schedules the transform of the held byte afterwards.
// ----------------------------------------------------------------------------
module mbc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_start,
  output logic                   in_ready,
  input  wire mbc_pkg::mbc_stat_t stat,
  output mbc_pkg::mbc_cmd_t      cmd
);
  import mbc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DERIVE = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // A beat is taken only in idle and only when the output slot can take it.
  assign in_ready = (state == ST_IDLE) && !stat.out_busy;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_start) begin
            cmd.init   = 1'b1;
            state_next = ST_DERIVE;
          end else begin
            cmd.xform  = 1'b1;
          end
        end
      end
      ST_DERIVE: begin
        if (stat.walk_done) begin
          cmd.seal   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          cmd.step   = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.xform    = 1'b1;
          cmd.use_held = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : mbc_ctrl
`default_nettype wire

// ===== sv/mbc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_datapath
// Datapath of the byte cipher: configuration registers, key walk for the sum
// and hash seed, per-byte transform and the output register.
// ----------------------------------------------------------------------------
module mbc_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [mbc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [mbc_pkg::KEY_WORD_W-1:0]         cfg_data,
  input  wire logic [7:0]                             in_byte,
  input  wire mbc_pkg::mbc_cmd_t                      cmd,
  output mbc_pkg::mbc_stat_t                          stat,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [7:0]                                  out_byte
);
  import mbc_pkg::*;

  // Configuration registers.
  logic [2:0]            cipher_mode;
  logic                  decrypt_mode;
  logic [KLEN_W-1:0]     key_length;
  logic [KEY_WORD_W-1:0] key_low;
  logic [KEY_WORD_W-1:0] key_high;

  // Cipher state.
  logic [POS_W-1:0]      key_position;
  logic [31:0]           keystream_word;
  logic [7:0]            key_sum;
  logic [KLEN_W-1:0]     walk_cnt;
  logic [7:0]            held_byte;

  logic [KLEN_W-1:0]     n_eff;
  logic [7:0]            walk_byte;
  logic [31:0]           hash_next;
  logic [7:0]            d;
  logic [POS_W-1:0]      p;
  logic [7:0]            kb;
  logic [31:0]           ks_a;
  logic [31:0]           ks_b;
  logic [31:0]           ks_next;
  logic [7:0]            r;
  logic [POS_W-1:0]      pos_next;
  logic [KLEN_W-1:0]     p_inc;

  assign n_eff = eff_len(key_length);

  // Key walk: one key byte per cycle into the sum and the FNV-1a hash.
  assign walk_byte = key_byte(key_low, key_high, walk_cnt[POS_W-1:0]);
  assign hash_next = 32'((keystream_word ^ {24'd0, walk_byte}) * FNV_PRIME);

  assign stat.walk_done = (walk_cnt == n_eff);
  assign stat.out_busy  = out_valid && !out_ready;

  // Key byte for the current position, with a stale position folded to zero.
  assign d  = cmd.use_held ? held_byte : in_byte;
  assign p  = ({1'b0, key_position} >= n_eff) ? '0 : key_position;
  assign kb = (n_eff == '0) ? 8'd0 : key_byte(key_low, key_high, p);

  // One xorshift32 step.
  assign ks_a    = keystream_word ^ (keystream_word << 13);
  assign ks_b    = ks_a ^ (ks_a >> 17);
  assign ks_next = ks_b ^ (ks_b << 5);

  // Byte transform by mode.
  always_comb begin
    case (cipher_mode)
      MODE_XOR:      r = d ^ kb;
      MODE_CAESAR:   r = decrypt_mode ? (d - key_sum) : (d + key_sum);
      MODE_VIGENERE: r = decrypt_mode ? (d - kb) : (d + kb);
      MODE_XORSHIFT: r = d ^ ks_next[7:0];
      MODE_ROTATE:   r = decrypt_mode ? rotr8(d ^ kb, key_sum[2:0])
                                      : (rotl8(d, key_sum[2:0]) ^ kb);
      default:       r = d;
    endcase
  end

  // Position advance with wrap at the key length.
  assign p_inc    = {1'b0, p} + KLEN_W'(1);
  assign pos_next = ((n_eff == '0) || (p_inc >= n_eff)) ? '0 : p_inc[POS_W-1:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_mode  <= MODE_XOR;
      decrypt_mode <= 1'b0;
      key_length   <= '0;
      key_low      <= '0;
      key_high     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CIPHER_MODE: cipher_mode  <= cfg_data[2:0];
        REG_DECRYPT:     decrypt_mode <= cfg_data[0];
        REG_KEY_LENGTH:  key_length   <= cfg_data[KLEN_W-1:0];
        REG_KEY_LOW:     key_low      <= cfg_data;
        REG_KEY_HIGH:    key_high     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Cipher state: key walk and per-byte updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_position   <= '0;
      keystream_word <= '0;
      key_sum        <= '0;
      walk_cnt       <= '0;
    end else begin
      if (cmd.init) begin
        keystream_word <= FNV_OFFSET;
        key_sum        <= '0;
        walk_cnt       <= '0;
      end
      if (cmd.step) begin
        keystream_word <= hash_next;
        key_sum        <= key_sum + walk_byte;
        walk_cnt       <= walk_cnt + KLEN_W'(1);
      end
      if (cmd.seal) begin
        key_position <= '0;
        if (keystream_word == '0) begin
          keystream_word <= SEED_ALT;
        end
      end
      if (cmd.xform) begin
        key_position <= pos_next;
        if (cipher_mode == MODE_XORSHIFT) begin
          keystream_word <= ks_next;
        end
      end
    end
  end

  // Byte held across the key walk.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      held_byte <= in_byte;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.xform) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.xform) begin
      out_byte <= r;
    end
  end

endmodule : mbc_datapath
`default_nettype wire

// ===== sv/mbc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_checker
// Port-level checks for the byte cipher, bound to the top level.
// ----------------------------------------------------------------------------
module mbc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_start,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present right after reset");

  // A plain byte yields its result on the next cycle.
  a_plain_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_start) |=> out_valid)
    else $error("plain byte did not produce a result next cycle");

  // The key walk after a message start blocks further input.
  a_walk_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_start) |=> !in_ready)
    else $error("input taken during key walk");

  // A stalled result beat holds its byte.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
    else $error("stalled result beat changed");

endmodule : mbc_checker

bind multi_mode_byte_cipher mbc_checker u_mbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_start  (in_ch.message_start),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte)
);
`default_nettype wire

// ===== dv/cipher_result_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cipher_result_check
// Watches the configuration port and both byte channels of the cipher. It
// keeps its own copy of the key, the derived key sum and keystream, and the
// key position. For every input beat it works out the cipher byte in advance.
// Each output beat is compared against the oldest byte still waiting.
// ----------------------------------------------------------------------------
module cipher_result_check
  import mbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KEY_WORD_W-1:0] cfg_data,
  mbc_in_if                     in_ch,
  mbc_out_if                    out_ch,
  output int unsigned           failures,
  output int unsigned           bytes_in_flight
);

  // Shadow of the configuration registers.
  logic [2:0]            mode_reg;
  logic                  decrypting;
  logic [KLEN_W-1:0]     key_len;
  logic [KEY_WORD_W-1:0] key_lo;
  logic [KEY_WORD_W-1:0] key_hi;

  // Running cipher state.
  logic [POS_W-1:0] walk_pos;
  logic [31:0]      stream_word;
  logic [7:0]       key_total;

  // Cipher bytes still owed by the block, oldest first.
  logic [7:0] expected_bytes[$];

  function automatic logic [7:0] key_at(input int unsigned idx);
    if (idx < 8) begin
      return key_lo[idx*8 +: 8];
    end
    return key_hi[(idx-8)*8 +: 8];
  endfunction

  // Works out the cipher byte for one input beat and advances the state.
  function automatic logic [7:0] cipher_next_byte(input logic [7:0] d, input logic start);
    int unsigned n;
    int unsigned pos;
    logic [7:0]  kb;
    logic [7:0]  mixed;
    logic [7:0]  r;
    logic [31:0] h;
    logic [2:0]  sh;
    n = (key_len > KEY_MAX_BYTES) ? KEY_MAX_BYTES : key_len;

    // A message start folds the key into a fresh sum and keystream seed.
    if (start) begin
      key_total = 8'h00;
      h = FNV_OFFSET;
      for (int i = 0; i < n; i++) begin
        key_total = key_total + key_at(i);
        h = (h ^ key_at(i)) * FNV_PRIME;
      end
      stream_word = (h == 32'h0) ? SEED_ALT : h;
      walk_pos = '0;
    end

    // A position left past a shortened key falls back to the first byte.
    pos = (walk_pos >= n) ? 0 : walk_pos;
    kb = (n == 0) ? 8'h00 : key_at(pos);
    sh = key_total[2:0];

    case (mode_reg)
      MODE_XOR: begin
        r = d ^ kb;
      end
      MODE_CAESAR: begin
        r = decrypting ? d - key_total : d + key_total;
      end
      MODE_VIGENERE: begin
        r = decrypting ? d - kb : d + kb;
      end
      MODE_XORSHIFT: begin
        stream_word ^= stream_word << 13;
        stream_word ^= stream_word >> 17;
        stream_word ^= stream_word << 5;
        r = d ^ stream_word[7:0];
      end
      MODE_ROTATE: begin
        if (decrypting) begin
          mixed = d ^ kb;
          r = (mixed >> sh) | (mixed << (4'd8 - sh));
        end else begin
          r = ((d << sh) | (d >> (4'd8 - sh))) ^ kb;
        end
      end
      default: begin
        r = d;
      end
    endcase

    walk_pos = (n == 0 || pos + 1 >= n) ? '0 : POS_W'(pos + 1);
    return r;
  endfunction

  // Register writes, output comparison, then prediction of the new beat.
  always @(posedge clk) begin
    logic [7:0] want;
    logic [7:0] fresh;
    if (rst) begin
      mode_reg    = MODE_XOR;
      decrypting  = 1'b0;
      key_len     = '0;
      key_lo      = '0;
      key_hi      = '0;
      walk_pos    = '0;
      stream_word = '0;
      key_total   = '0;
      expected_bytes.delete();
      failures    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CIPHER_MODE: mode_reg = cfg_data[2:0];
          REG_DECRYPT:     decrypting = cfg_data[0];
          REG_KEY_LENGTH:  key_len = cfg_data[KLEN_W-1:0];
          REG_KEY_LOW:     key_lo = cfg_data;
          REG_KEY_HIGH:    key_hi = cfg_data;
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: no byte expected, actual %02h", out_ch.out_byte);
          failures++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.out_byte !== want) begin
            $error("out_byte: expected %02h, actual %02h", want, out_ch.out_byte);
            failures++;
          end
        end
      end

      // The newest predicted byte joins the tail of the queue.
      if (in_ch.valid && in_ch.ready) begin
        fresh = cipher_next_byte(in_ch.data_byte, in_ch.message_start);
        expected_bytes = {expected_bytes, fresh};
      end
    end
    bytes_in_flight <= expected_bytes.size();
  end

endmodule : cipher_result_check

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the byte cipher with a short directed pass and then random keyed
// messages. Mode, direction, key length and key words are changed between
// bursts. Both channel sides stall at random, and one long output stall
// backs the block up. The checker beside the block does the comparison,
// and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import mbc_pkg::*;

  localparam int unsigned TOTAL_BYTES  = 1900;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 300;

  // Mode codes the block does not define; they pass bytes through.
  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [KEY_WORD_W-1:0] cfg_data;

  int unsigned mismatch_total;
  int unsigned bytes_in_flight;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 48;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;

  mbc_in_if  in_ch();
  mbc_out_if out_ch();

  multi_mode_byte_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  cipher_result_check result_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .failures        (mismatch_total),
    .bytes_in_flight (bytes_in_flight)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off once requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [2:0] mode_code(input int unsigned k);
    case (k)
      0: return MODE_XOR;
      1: return MODE_CAESAR;
      2: return MODE_VIGENERE;
      3: return MODE_XORSHIFT;
      4: return MODE_ROTATE;
      5: return MODE_SPARE_5;
      6: return MODE_SPARE_6;
      default: return MODE_SPARE_7;
    endcase
  endfunction

  function automatic logic [KEY_WORD_W-1:0] random_key_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      return '1;
    end
    if (pick < 20) begin
      return '0;
    end
    return {$urandom, $urandom};
  endfunction

  // One register write; the enable drops again before the task returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [KEY_WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one beat after a random gap and hold it until it is taken.
  task automatic send_byte(input logic [7:0] value, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= value;
    in_ch.message_start <= first;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  // Random message body; a stray start now and then restarts the key walk.
  task automatic send_message(input int unsigned len, input logic opens);
    for (int unsigned j = 0; j < len; j++) begin
      send_byte(8'($urandom), (j == 0) ? opens : ($urandom_range(99) < 3));
    end
  endtask

  // Stop offering and wait until every predicted byte has come out.
  task automatic wait_all_bytes_out();
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (bytes_in_flight != 0);
  endtask

  initial begin
    int unsigned pick;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_CIPHER_MODE;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = 8'h00;
    in_ch.message_start = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration, no message start yet: the empty key passes bytes.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_all_bytes_out();

    // Key written but never derived: caesar shifts by zero and the keystream
    // stays zero.
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LENGTH, 64'd16);
    write_reg(REG_CIPHER_MODE, 64'(MODE_CAESAR));
    send_byte(8'h7F, 1'b0);
    wait_all_bytes_out();
    write_reg(REG_CIPHER_MODE, 64'(MODE_XORSHIFT));
    send_byte(8'h80, 1'b0);
    wait_all_bytes_out();

    // Oversized key length with every mode code, encrypting.
    write_reg(REG_KEY_LENGTH, 64'd31);
    for (int k = 0; k < 8; k++) begin
      write_reg(REG_CIPHER_MODE, 64'(mode_code(k)));
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      wait_all_bytes_out();
    end

    // Decrypting with a key whose sum gives a zero rotation.
    write_reg(REG_DECRYPT, 64'd1);
    write_reg(REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_CIPHER_MODE, 64'(MODE_CAESAR));
    send_byte(8'hA5, 1'b1);
    wait_all_bytes_out();
    write_reg(REG_CIPHER_MODE, 64'(MODE_VIGENERE));
    send_byte(8'hA5, 1'b1);
    wait_all_bytes_out();
    write_reg(REG_CIPHER_MODE, 64'(MODE_ROTATE));
    send_byte(8'hA5, 1'b1);

    // Random bursts of messages, reconfigured between bursts.
    while (bytes_sent < TOTAL_BYTES) begin
      if (bytes_sent < TOTAL_BYTES / 3) begin
        send_idle_pct = 28;
        recv_idle_pct <= 48;
      end else if (bytes_sent < 2 * TOTAL_BYTES / 3) begin
        send_idle_pct = 48;
        recv_idle_pct <= 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      wait_all_bytes_out();

      if ($urandom_range(99) < 70) begin
        pick = ($urandom_range(99) < 85) ? $urandom_range(4) : $urandom_range(5, 7);
        write_reg(REG_CIPHER_MODE, 64'(mode_code(pick)));
      end
      if ($urandom_range(99) < 40) begin
        write_reg(REG_DECRYPT, 64'($urandom_range(1)));
      end
      if ($urandom_range(99) < 50) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          write_reg(REG_KEY_LENGTH, 64'd0);
        end else if (pick < 16) begin
          write_reg(REG_KEY_LENGTH, 64'($urandom_range(17, 31)));
        end else begin
          write_reg(REG_KEY_LENGTH, 64'($urandom_range(1, 16)));
        end
      end
      if ($urandom_range(99) < 40) begin
        write_reg(REG_KEY_LOW, random_key_word());
      end
      if ($urandom_range(99) < 40) begin
        write_reg(REG_KEY_HIGH, random_key_word());
      end

      if (!hold_req && bytes_sent >= TOTAL_BYTES / 2) begin
        // Output stalls for a long stretch while beats keep coming, so the
        // block backs up and stops taking input.
        send_idle_pct = 0;
        hold_req <= 1'b1;
        send_message(60, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_message($urandom_range(1, 40), $urandom_range(99) < 85);
        end
      end
    end

    wait_all_bytes_out();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : testbench

// ===== filelist.f =====
sv/mbc_pkg.sv
sv/mbc_in_if.sv
sv/mbc_out_if.sv
sv/mbc_ctrl.sv
sv/mbc_datapath.sv
sv/multi_mode_byte_cipher.sv
sv/mbc_checker.sv
dv/cipher_result_check.sv
dv/testbench.sv
